### design/dwvr_pkg.sv
package dwvr_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int VAL_W = 32;
	localparam int Q_DEPTH = 2;
	localparam int QP_W = $clog2(Q_DEPTH);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [3:0] KIND_PUSH_FRONT = 4'd0;
	localparam logic [3:0] KIND_PUSH_BACK = 4'd1;
	localparam logic [3:0] KIND_POP_FRONT = 4'd2;
	localparam logic [3:0] KIND_POP_BACK = 4'd3;
	localparam logic [3:0] KIND_CLEAR = 4'd4;
	localparam logic [3:0] KIND_REMOVE = 4'd5;
	localparam logic [3:0] KIND_READ_ALL = 4'd6;
	localparam logic [3:0] KIND_READ_FIRST = 4'd7;
	localparam logic [3:0] KIND_READ_LAST = 4'd8;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [3:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_CLEAR,
		OP_REMOVE,
		OP_READ_ALL,
		OP_READ_FIRST,
		OP_READ_LAST,
		OP_NOP
	} op_e;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_REMOVE,
		BK_REMOVE_DONE,
		BK_READ
	} bk_state_e;

	typedef struct packed {
		logic [3:0] kind;
		logic signed [VAL_W-1:0] operand;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] item_value;
		logic has_item;
		logic [1:0] status;
		logic last;
	} res_t;

	typedef struct packed {
		op_e op;
		logic [VAL_W-1:0] value;
		logic cnt_sat;
		cnt_t cnt;
	} work_t;

	function automatic idx_t ring_add(input idx_t base, input cnt_t off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(CAPACITY)) begin
			sum = sum - (CNT_W + 1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

	function automatic idx_t ring_dec(input idx_t base);
		idx_t r;
		if (base == '0) begin
			r = IDX_W'(CAPACITY - 1);
		end else begin
			r = base - IDX_W'(1);
		end
		return r;
	endfunction

endpackage

### design/dwvr_front.sv
module dwvr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  dwvr_pkg::cmd_t cmd,
	output logic work_valid,
	input  logic work_ready,
	output dwvr_pkg::work_t work
);
	import dwvr_pkg::*;

	logic valid_s1;
	work_t work_s1;
	work_t decoded;
	logic neg;
	logic big;

	assign cmd_stall = valid_s1 && !work_ready;
	assign work_valid = valid_s1;
	assign work = work_s1;

	always_comb begin
		neg = cmd.operand[VAL_W-1];
		big = !neg && ($unsigned(cmd.operand) > VAL_W'(CAPACITY));
		decoded.value = cmd.operand;
		decoded.cnt_sat = big;
		decoded.cnt = (neg || big) ? '0 : cmd.operand[CNT_W-1:0];
		unique case (cmd.kind)
			KIND_PUSH_FRONT: decoded.op = OP_PUSH_FRONT;
			KIND_PUSH_BACK:  decoded.op = OP_PUSH_BACK;
			KIND_POP_FRONT:  decoded.op = OP_POP_FRONT;
			KIND_POP_BACK:   decoded.op = OP_POP_BACK;
			KIND_CLEAR:      decoded.op = OP_CLEAR;
			KIND_REMOVE:     decoded.op = OP_REMOVE;
			KIND_READ_ALL:   decoded.op = OP_READ_ALL;
			KIND_READ_FIRST: decoded.op = OP_READ_FIRST;
			KIND_READ_LAST:  decoded.op = OP_READ_LAST;
			default:         decoded.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			work_s1 <= decoded;
		end
	end

endmodule

### design/dwvr_cmdq.sv
module dwvr_cmdq (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  dwvr_pkg::work_t push_data,
	output logic pop_valid,
	input  logic pop,
	output dwvr_pkg::work_t pop_data
);
	import dwvr_pkg::*;

	work_t slots_q [Q_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QP_W:0] fill_q;
	logic do_push;
	logic do_pop;

	assign push_ready = fill_q != (QP_W + 1)'(Q_DEPTH);
	assign pop_valid = fill_q != '0;
	assign pop_data = slots_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QP_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (QP_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (QP_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### design/dwvr_back.sv
module dwvr_back (
	input  logic clk,
	input  logic arst_n,
	input  logic work_valid,
	output logic work_pop,
	input  dwvr_pkg::work_t work,
	output logic res_valid,
	input  logic res_stall,
	output dwvr_pkg::res_t res
);
	import dwvr_pkg::*;

	logic [VAL_W-1:0] mem_q [CAPACITY];
	idx_t front_q, front_d;
	cnt_t count_q, count_d;
	bk_state_e state_q, state_d;
	cnt_t i_q, i_d;
	cnt_t kept_q, kept_d;
	cnt_t n_q, n_d;
	idx_t base_q, base_d;
	logic [VAL_W-1:0] val_q, val_d;
	logic [VAL_W-1:0] rd_data_q;
	logic res_valid_q;
	res_t res_q;

	logic out_free;
	logic emit;
	res_t res_d;
	logic mem_we;
	idx_t mem_wa;
	logic [VAL_W-1:0] mem_wd;
	idx_t rd_idx;
	cnt_t n_req;
	logic full;
	logic empty;

	assign out_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res = res_q;
	assign full = count_q == CNT_W'(CAPACITY);
	assign empty = count_q == '0;
	assign rd_idx = (state_d == BK_READ) ? ring_add(base_d, i_d) : ring_add(front_d, i_d);

	always_comb begin
		if (work.op == OP_READ_ALL || work.cnt_sat || work.cnt > count_q) begin
			n_req = count_q;
		end else begin
			n_req = work.cnt;
		end
	end

	always_comb begin
		state_d = state_q;
		front_d = front_q;
		count_d = count_q;
		i_d = i_q;
		kept_d = kept_q;
		n_d = n_q;
		base_d = base_q;
		val_d = val_q;
		work_pop = 1'b0;
		emit = 1'b0;
		res_d.item_value = '0;
		res_d.has_item = 1'b0;
		res_d.status = ST_OK;
		res_d.last = 1'b1;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = work.value;
		unique case (state_q)
			BK_IDLE: begin
				if (work_valid && out_free) begin
					work_pop = 1'b1;
					case (work.op) inside
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							emit = 1'b1;
							if (full) begin
								res_d.status = ST_FULL;
							end else begin
								mem_we = 1'b1;
								count_d = count_q + CNT_W'(1);
								if (work.op == OP_PUSH_FRONT) begin
									mem_wa = ring_dec(front_q);
									front_d = ring_dec(front_q);
								end else begin
									mem_wa = ring_add(front_q, count_q);
								end
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							emit = 1'b1;
							if (empty) begin
								res_d.status = ST_EMPTY;
							end else begin
								count_d = count_q - CNT_W'(1);
								if (work.op == OP_POP_FRONT) begin
									front_d = ring_add(front_q, CNT_W'(1));
								end
							end
						end
						OP_CLEAR: begin
							emit = 1'b1;
							count_d = '0;
						end
						OP_REMOVE: begin
							if (empty) begin
								emit = 1'b1;
								res_d.status = ST_EMPTY;
							end else begin
								state_d = BK_REMOVE;
								i_d = '0;
								kept_d = '0;
								val_d = work.value;
							end
						end
						OP_READ_ALL, OP_READ_FIRST, OP_READ_LAST: begin
							if (empty) begin
								emit = 1'b1;
								res_d.status = ST_EMPTY;
							end else if (n_req == '0) begin
								emit = 1'b1;
							end else begin
								state_d = BK_READ;
								i_d = '0;
								n_d = n_req;
								if (work.op == OP_READ_LAST) begin
									base_d = ring_add(front_q, count_q - n_req);
								end else begin
									base_d = front_q;
								end
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			BK_REMOVE: begin
				kept_d = kept_q;
				if (rd_data_q != val_q) begin
					mem_we = 1'b1;
					mem_wa = ring_add(front_q, kept_q);
					mem_wd = rd_data_q;
					kept_d = kept_q + CNT_W'(1);
				end
				i_d = i_q + CNT_W'(1);
				if (i_q == count_q - CNT_W'(1)) begin
					count_d = kept_d;
					state_d = BK_REMOVE_DONE;
				end
			end
			BK_REMOVE_DONE: begin
				if (out_free) begin
					emit = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_READ: begin
				if (out_free) begin
					emit = 1'b1;
					res_d.item_value = rd_data_q;
					res_d.has_item = 1'b1;
					res_d.last = i_q == n_q - CNT_W'(1);
					i_d = i_q + CNT_W'(1);
					if (res_d.last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			front_q <= '0;
			count_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			if (out_free) begin
				res_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d;
		kept_q <= kept_d;
		n_q <= n_d;
		base_q <= base_d;
		val_q <= val_d;
		if (emit) begin
			res_q <= res_d;
		end
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem_q[rd_idx];
	end

endmodule

### design/deque_with_value_removal.sv
// Push, pop, clear and ignored commands pass the front register and queue to a registered result.
// The first result of a read-out comes from a registered store read and is itself registered.
// Push, pop, clear and ignored commands sustain one transaction per cycle while res_stall is low.
// A read-out gives one result per cycle while res_stall is low, via the single store read port.
// Value removal walks the stored entries and keeps only those unequal to the value.
// Reset clears the front index, the entry count and all handshake state; the store is not cleared.
module deque_with_value_removal (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  dwvr_pkg::cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output dwvr_pkg::res_t res
);
	import dwvr_pkg::*;

	logic fw_valid;
	logic fw_ready;
	work_t fw_work;
	logic bk_valid;
	logic bk_pop;
	work_t bk_work;

	dwvr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.work_valid(fw_valid),
		.work_ready(fw_ready),
		.work(fw_work)
	);

	dwvr_cmdq u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(fw_valid),
		.push_ready(fw_ready),
		.push_data(fw_work),
		.pop_valid(bk_valid),
		.pop(bk_pop),
		.pop_data(bk_work)
	);

	dwvr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.work_valid(bk_valid),
		.work_pop(bk_pop),
		.work(bk_work),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

endmodule
